[sv/pkd_pkg.sv]
// Shared constants and controller/datapath interface types for the prefix key decompressor.
package pkd_pkg;

    localparam int KEY_BYTES_DEF = 48;
    localparam int BYTE_W        = 8;
    localparam int VARINT_W      = 32;
    localparam int SHIFT_W       = 3;
    localparam int LAST_GROUP    = 4;

    typedef struct packed {
        logic step;
        logic load_len;
        logic load_ctrl;
        logic load_pfx;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic header_ok;
        logic pfx_empty;
        logic pfx_last;
    } dp_status_t;

endpackage

[sv/prefix_key_decompressor_core.sv]
// Top level: front-coded key stream in, full serialized keys out, one byte per request.
// Each request's result is registered for the next cycle; one request per cycle while parsing
// and the output register is free. A valid record header stalls requests while the length, the
//   control byte and m prefix bytes (m = shared prefix) go out; prefix bytes come from the registered store read.
// Reset: asynchronous, active low; clears parser and controller state.
// Key store contents stay undefined until written and get no clearing pass.
module prefix_key_decompressor_core #(
    parameter int KEY_BYTES = pkd_pkg::KEY_BYTES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // [0] mode
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast,
    output logic       m_tuser    // [0] error
);

    pkd_pkg::dp_cmd_t    cmd;
    pkd_pkg::dp_status_t status;

    pkd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pkd_datapath #(
        .KEY_BYTES (KEY_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_mode   (s_tuser),
        .in_byte   (s_tdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_byte  (m_tdata),
        .out_last  (m_tlast),
        .out_error (m_tuser)
    );

endmodule

[sv/pkd_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module pkd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 48
) (
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                            wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/pkd_datapath.sv]
// Datapath: record parser registers, key store access and output register.
module pkd_datapath #(
    parameter int KEY_BYTES = pkd_pkg::KEY_BYTES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pkd_pkg::dp_cmd_t           cmd,
    output pkd_pkg::dp_status_t        status,
    input  logic                       in_mode,
    input  logic [pkd_pkg::BYTE_W-1:0] in_byte,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic [pkd_pkg::BYTE_W-1:0] out_byte,
    output logic                       out_last,
    output logic                       out_error
);

    localparam int LW = $clog2(KEY_BYTES + 1);
    localparam int AW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam int VW = pkd_pkg::VARINT_W;
    localparam int BW = pkd_pkg::BYTE_W;
    localparam int SW = pkd_pkg::SHIFT_W;

    typedef enum logic [2:0] {
        PH_LEN,
        PH_CTRL,
        PH_SHARED,
        PH_SUFFIX,
        PH_SKIP
    } phase_t;

    phase_t          phase_reg, phase_next;
    logic [VW-1:0]   accum_reg, accum_next;
    logic [SW-1:0]   shift_reg, shift_next;
    logic [VW-1:0]   left_reg, left_next;
    logic [LW-1:0]   prev_len_reg, prev_len_next;
    logic [LW-1:0]   shared_reg, shared_next;
    logic [LW-1:0]   wpos_reg, wpos_next;
    logic [LW-1:0]   idx_reg, idx_next;
    logic [BW-1:0]   ctrl_reg, ctrl_next;
    logic            s_zero_reg, s_zero_next;
    logic            out_valid_reg, out_valid_next;
    logic [BW-1:0]   out_byte_reg, out_byte_next;
    logic            out_last_reg, out_last_next;
    logic            out_err_reg, out_err_next;

    logic [VW-1:0]   group_w;
    logic [VW-1:0]   accum_or;
    logic [VW-1:0]   left_dec;
    logic            more;
    logic            last_group;
    logic [LW-1:0]   m_lo;
    logic [LW-1:0]   s_lo;
    logic [LW:0]     body_sum;
    logic            too_long;
    logic            too_big;
    logic            header_ok;
    logic            res_valid;
    logic [BW-1:0]   res_byte;
    logic            res_last;
    logic            res_err;
    logic            ram_we;
    logic [BW-1:0]   ram_rd;
    logic            out_free;

    pkd_ram #(
        .WIDTH (BW),
        .DEPTH (KEY_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wpos_reg[AW-1:0]),
        .wr_data (in_byte),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (ram_rd)
    );

    // 7-bit varint group placed at its position; only 4 bits survive the last group
    always_comb
    begin
        case (shift_reg)
            3'd0:    group_w = {{(VW-7){1'b0}}, in_byte[6:0]};
            3'd1:    group_w = {{(VW-14){1'b0}}, in_byte[6:0], 7'd0};
            3'd2:    group_w = {{(VW-21){1'b0}}, in_byte[6:0], 14'd0};
            3'd3:    group_w = {{(VW-28){1'b0}}, in_byte[6:0], 21'd0};
            3'd4:    group_w = {in_byte[3:0], 28'd0};
            default: group_w = '0;
        endcase
    end

    assign accum_or   = accum_reg | group_w;
    assign left_dec   = left_reg - VW'(1);
    assign more       = in_byte[7];
    assign last_group = (shift_reg == SW'(pkd_pkg::LAST_GROUP));
    assign m_lo       = accum_or[LW-1:0];
    assign s_lo       = left_dec[LW-1:0];
    assign body_sum   = {1'b0, m_lo} + {1'b0, s_lo};
    assign too_long   = (accum_or[VW-1:LW] != '0) || (m_lo > prev_len_reg);
    assign too_big    = (left_dec[VW-1:LW] != '0) || (body_sum > (LW+1)'(KEY_BYTES));
    assign out_free   = !out_valid_reg || out_ready;

    // Parser step for one accepted request
    always_comb
    begin
        phase_next    = phase_reg;
        accum_next    = accum_reg;
        shift_next    = shift_reg;
        left_next     = left_reg;
        prev_len_next = prev_len_reg;
        shared_next   = shared_reg;
        wpos_next     = wpos_reg;
        ctrl_next     = ctrl_reg;
        s_zero_next   = s_zero_reg;
        header_ok     = 1'b0;
        res_valid     = 1'b0;
        res_byte      = '0;
        res_last      = 1'b1;
        res_err       = 1'b1;
        ram_we        = 1'b0;

        if (cmd.step)
        begin
            if (in_mode)
            begin
                prev_len_next = '0;
                phase_next    = PH_LEN;
                accum_next    = '0;
                shift_next    = '0;
                left_next     = '0;
            end
            else
            begin
                case (phase_reg)
                    PH_CTRL:
                    begin
                        ctrl_next  = in_byte;
                        left_next  = left_dec;
                        accum_next = '0;
                        shift_next = '0;
                        if (left_dec == '0)
                        begin
                            phase_next = PH_LEN;
                            res_valid  = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_SHARED;
                        end
                    end

                    PH_SHARED:
                    begin
                        left_next = left_dec;
                        if (more)
                        begin
                            if (last_group || left_dec == '0)
                            begin
                                accum_next = '0;
                                shift_next = '0;
                                phase_next = (left_dec == '0) ? PH_LEN : PH_SKIP;
                                res_valid  = 1'b1;
                            end
                            else
                            begin
                                accum_next = accum_or;
                                shift_next = shift_reg + SW'(1);
                            end
                        end
                        else
                        begin
                            accum_next = '0;
                            shift_next = '0;
                            if (too_long || too_big)
                            begin
                                phase_next = (left_dec == '0) ? PH_LEN : PH_SKIP;
                                res_valid  = 1'b1;
                            end
                            else
                            begin
                                header_ok     = 1'b1;
                                shared_next   = m_lo;
                                wpos_next     = m_lo;
                                prev_len_next = body_sum[LW-1:0];
                                s_zero_next   = (left_dec == '0);
                                phase_next    = (left_dec == '0) ? PH_LEN : PH_SUFFIX;
                            end
                        end
                    end

                    PH_SUFFIX:
                    begin
                        ram_we     = 1'b1;
                        wpos_next  = wpos_reg + LW'(1);
                        left_next  = left_dec;
                        res_valid  = 1'b1;
                        res_byte   = in_byte;
                        res_last   = (left_dec == '0);
                        res_err    = 1'b0;
                        if (left_dec == '0)
                        begin
                            phase_next = PH_LEN;
                        end
                    end

                    PH_SKIP:
                    begin
                        if (left_reg != '0)
                        begin
                            left_next = left_dec;
                        end
                        if (left_reg == '0 || left_dec == '0)
                        begin
                            phase_next = PH_LEN;
                        end
                    end

                    default:
                    begin
                        phase_next = PH_LEN;
                        if (more)
                        begin
                            if (last_group)
                            begin
                                accum_next = '0;
                                shift_next = '0;
                                res_valid  = 1'b1;
                            end
                            else
                            begin
                                accum_next = accum_or;
                                shift_next = shift_reg + SW'(1);
                            end
                        end
                        else
                        begin
                            left_next  = accum_or;
                            accum_next = '0;
                            shift_next = '0;
                            if (accum_or == '0)
                            begin
                                res_valid = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_CTRL;
                            end
                        end
                    end
                endcase
            end
        end
    end

    // Output register and prefix counter
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_err_next   = out_err_reg;
        idx_next       = idx_reg;

        if (header_ok)
        begin
            idx_next = '0;
        end

        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = res_byte;
            out_last_next  = res_last;
            out_err_next   = res_err;
        end
        else if (cmd.load_len)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = BW'(prev_len_reg) + BW'(1);
            out_last_next  = 1'b0;
            out_err_next   = 1'b0;
        end
        else if (cmd.load_ctrl)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = ctrl_reg;
            out_last_next  = status.pfx_empty && s_zero_reg;
            out_err_next   = 1'b0;
        end
        else if (cmd.load_pfx)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = ram_rd;
            out_last_next  = status.pfx_last && s_zero_reg;
            out_err_next   = 1'b0;
            idx_next       = idx_reg + LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_LEN;
            accum_reg     <= '0;
            shift_reg     <= '0;
            left_reg      <= '0;
            prev_len_reg  <= '0;
            shared_reg    <= '0;
            wpos_reg      <= '0;
            idx_reg       <= '0;
            ctrl_reg      <= '0;
            s_zero_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            accum_reg     <= accum_next;
            shift_reg     <= shift_next;
            left_reg      <= left_next;
            prev_len_reg  <= prev_len_next;
            shared_reg    <= shared_next;
            wpos_reg      <= wpos_next;
            idx_reg       <= idx_next;
            ctrl_reg      <= ctrl_next;
            s_zero_reg    <= s_zero_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_err_reg  <= out_err_next;
    end

    assign status.out_free  = out_free;
    assign status.header_ok = header_ok;
    assign status.pfx_empty = (shared_reg == '0);
    assign status.pfx_last  = (LW'(idx_reg + LW'(1)) == shared_reg);

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign out_error = out_err_reg;

endmodule

[sv/pkd_ctrl.sv]
// Controller: accepts requests and sequences the emission of a key header and prefix.
module pkd_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  pkd_pkg::dp_status_t status,
    output pkd_pkg::dp_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT_LEN,
        ST_EMIT_CTRL,
        ST_PFX_RD,
        ST_PFX_WR
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        in_ready      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = status.out_free;
                cmd.step = in_valid && status.out_free;
                if (cmd.step && status.header_ok)
                begin
                    state_next = ST_EMIT_LEN;
                end
            end

            ST_EMIT_LEN:
            begin
                if (status.out_free)
                begin
                    cmd.load_len = 1'b1;
                    state_next   = ST_EMIT_CTRL;
                end
            end

            ST_EMIT_CTRL:
            begin
                if (status.out_free)
                begin
                    cmd.load_ctrl = 1'b1;
                    state_next    = status.pfx_empty ? ST_IDLE : ST_PFX_RD;
                end
            end

            // the key store registers the prefix byte at the read address here, before ST_PFX_WR takes it
            ST_PFX_RD:
            begin
                state_next = ST_PFX_WR;
            end

            ST_PFX_WR:
            begin
                if (status.out_free)
                begin
                    cmd.load_pfx = 1'b1;
                    state_next   = status.pfx_last ? ST_IDLE : ST_PFX_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[sim/testbench.sv]
// Self-checking testbench for the front-coded key decompressor: byte-level prediction and compare.
`timescale 1ns / 100ps

typedef enum logic [2:0] {
    RX_LENGTH,
    RX_CONTROL,
    RX_SHARED,
    RX_SUFFIX,
    RX_DISCARD
} rx_phase_t;

typedef struct packed {
    logic [7:0] value;
    logic       is_last;
    logic       is_err;
} key_out_t;

class key_scoreboard;
    localparam int BODY_MAX = pkd_pkg::KEY_BYTES_DEF;

    logic [7:0]  key_body [BODY_MAX];
    int unsigned body_len;
    int unsigned bytes_left;
    int unsigned shared_len;
    int unsigned wr_pos;
    logic [31:0] accum;
    int unsigned shift;
    logic [7:0]  ctrl_byte;
    rx_phase_t   phase;
    key_out_t    expected_q[$];
    int          mismatches;
    int          results_checked;
    int          error_results;

    function new();
        body_len        = 0;
        bytes_left      = 0;
        shared_len      = 0;
        wr_pos          = 0;
        accum           = '0;
        shift           = 0;
        ctrl_byte       = '0;
        phase           = RX_LENGTH;
        mismatches      = 0;
        results_checked = 0;
        error_results   = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void push(logic [7:0] value, logic is_last, logic is_err);
        key_out_t item;
        item.value   = value;
        item.is_last = is_last;
        item.is_err  = is_err;
        expected_q.push_back(item);
    endfunction

    function void push_error();
        push(8'h00, 1'b1, 1'b1);
    endfunction

    // 7-bit groups, least significant first; groups past bit 31 fall off
    function void add_group(logic [7:0] b);
        logic [31:0] grp;
        int unsigned sh;
        sh  = (shift & 7) * 7;
        grp = {25'd0, b[6:0]};
        if (sh < 32)
            accum = accum | (grp << sh);
    endfunction

    function void close_record();
        phase = (bytes_left == 0) ? RX_LENGTH : RX_DISCARD;
    endfunction

    function void note_request(logic mode, logic [7:0] b);
        longint unsigned m;
        longint unsigned s;
        if (mode)
        begin
            body_len   = 0;
            phase      = RX_LENGTH;
            accum      = '0;
            shift      = 0;
            bytes_left = 0;
            return;
        end
        case (phase)
            RX_CONTROL:
            begin
                ctrl_byte = b;
                bytes_left--;
                accum = '0;
                shift = 0;
                if (bytes_left == 0)
                begin
                    phase = RX_LENGTH;
                    push_error();
                end
                else
                    phase = RX_SHARED;
            end
            RX_SHARED:
            begin
                bytes_left--;
                add_group(b);
                if (b[7])
                begin
                    if (shift >= 4 || bytes_left == 0)
                    begin
                        accum = '0;
                        shift = 0;
                        close_record();
                        push_error();
                    end
                    else
                        shift++;
                end
                else
                begin
                    m     = accum;
                    s     = bytes_left;
                    accum = '0;
                    shift = 0;
                    if (m > body_len || m + s > BODY_MAX)
                    begin
                        close_record();
                        push_error();
                    end
                    else
                    begin
                        shared_len = m;
                        wr_pos     = m;
                        body_len   = m + s;
                        push(8'(1 + m + s), 1'b0, 1'b0);
                        push(ctrl_byte, (s == 0 && m == 0), 1'b0);
                        for (int i = 0; i < shared_len; i++)
                            push(key_body[i], (s == 0 && i == shared_len - 1), 1'b0);
                        phase = (s == 0) ? RX_LENGTH : RX_SUFFIX;
                    end
                end
            end
            RX_SUFFIX:
            begin
                if (wr_pos < BODY_MAX)
                    key_body[wr_pos] = b;
                wr_pos++;
                bytes_left--;
                push(b, (bytes_left == 0), 1'b0);
                if (bytes_left == 0)
                    phase = RX_LENGTH;
            end
            RX_DISCARD:
            begin
                if (bytes_left != 0)
                    bytes_left--;
                if (bytes_left == 0)
                    phase = RX_LENGTH;
            end
            default:
            begin
                phase = RX_LENGTH;
                add_group(b);
                if (b[7])
                begin
                    if (shift >= 4)
                    begin
                        accum = '0;
                        shift = 0;
                        push_error();
                    end
                    else
                        shift++;
                end
                else
                begin
                    bytes_left = accum;
                    accum      = '0;
                    shift      = 0;
                    if (bytes_left == 0)
                        push_error();
                    else
                        phase = RX_CONTROL;
                end
            end
        endcase
    endfunction

    task report(string what);
        mismatches++;
        $display("[%0t] ERROR: %s", $realtime, what);
    endtask

    task check_result(logic [7:0] value, logic is_last, logic is_err);
        key_out_t want;
        results_checked++;
        if (is_err)
            error_results++;
        if (expected_q.size() == 0)
        begin
            report($sformatf("unexpected byte %02h last=%0b err=%0b", value, is_last, is_err));
            return;
        end
        want = expected_q.pop_front();
        if (value !== want.value || is_last !== want.is_last || is_err !== want.is_err)
            report($sformatf("got byte %02h last=%0b err=%0b, want %02h last=%0b err=%0b",
                             value, is_last, is_err, want.value, want.is_last, want.is_err));
    endtask
endclass

module testbench;
    localparam int KEY_BYTES    = pkd_pkg::KEY_BYTES_DEF;
    localparam int RANDOM_ITEMS = 76;
    localparam int CALM_AFTER   = 60;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 2 + 2 * KEY_BYTES + 20;
    localparam int CYCLE_LIMIT  = 2000000;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] in_byte
    logic       s_tuser;   // [0] mode
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;   // [7:0] out_byte
    logic       m_tlast;
    logic       m_tuser;   // [0] error

    key_scoreboard sb = new();

    logic [7:0] rec_bytes[$];
    int         items_sent;
    int         reset_items;
    int         cycle_count;
    bit         tx_idle_en;
    bit         rx_idle_en;
    bit         hold_req;

    prefix_key_decompressor_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // LSB-first varint; pad adds redundant zero groups
    function automatic void put_varint(ref logic [7:0] q[$], input logic [31:0] v, input int pad);
        logic [6:0] grp;
        do
        begin
            grp = v[6:0];
            v   = v >> 7;
            q.push_back({(v != 0) || (pad > 0), grp});
        end
        while (v != 0);
        for (int k = 0; k < pad; k++)
            q.push_back({k < pad - 1, 7'd0});
    endfunction

    function automatic void build_record(int unsigned m, int unsigned s, int pad_m, int pad_len);
        logic [7:0] shared_enc[$];
        put_varint(shared_enc, m, pad_m);
        put_varint(rec_bytes, 1 + shared_enc.size() + s, pad_len);
        rec_bytes.push_back(8'($urandom));
        foreach (shared_enc[i])
            rec_bytes.push_back(shared_enc[i]);
        repeat (s)
            rec_bytes.push_back(8'($urandom));
    endfunction

    task automatic send_item(input logic mode, input logic [7:0] value);
        int gap;
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 19);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= value;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(mode, value);
        items_sent++;
        if (mode)
            reset_items++;
    endtask

    task automatic send_record_bytes(input int count);
        for (int i = 0; i < count && i < rec_bytes.size(); i++)
            send_item(1'b0, rec_bytes[i]);
    endtask

    // receiver: random stalls plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tlast, m_tuser);
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 7) == 0)
            begin
                hold_left = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int          first_random;
        int          pick;
        int unsigned prev;
        int unsigned m;
        int unsigned s;
        int unsigned smax;
        int          n;

        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= 8'h00;
        s_tuser     <= 1'b0;
        items_sent  = 0;
        reset_items = 0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        hold_req    = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset, empty record, plain key, prefix-only key, bad prefix,
        // record ending after control / inside shared count, overlong length varint
        send_item(1'b1, 8'hA5);
        rec_bytes = '{8'h00,
                      8'h04, 8'hFF, 8'h00, 8'h00, 8'hFF,
                      8'h02, 8'h5A, 8'h02,
                      8'h03, 8'h11, 8'h03, 8'h77,
                      8'h01, 8'h22,
                      8'h02, 8'h33, 8'h80,
                      8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
        send_record_bytes(rec_bytes.size());

        first_random = items_sent;
        hold_req     = 1'b1;
        while (items_sent - first_random < RANDOM_ITEMS)
        begin
            if (items_sent - first_random >= CALM_AFTER)
            begin
                tx_idle_en = 1'b0;
                rx_idle_en = 1'b0;
            end
            rec_bytes.delete();
            prev = sb.body_len;
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                m    = $urandom_range(0, 1) ? prev : $urandom_range(0, prev);
                smax = KEY_BYTES - m;
                s    = ($urandom_range(0, 4) == 0) ? $urandom_range(0, smax)
                                                   : $urandom_range(0, (smax < 6) ? smax : 6);
                build_record(m, s,
                             ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0,
                             ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0);
                send_record_bytes(rec_bytes.size());
            end
            else if (pick < 78)
            begin
                // key too large for the store
                m = $urandom_range(0, prev);
                build_record(m, KEY_BYTES - m + $urandom_range(1, 4), 0, 0);
                send_record_bytes(rec_bytes.size());
            end
            else if (pick < 84)
            begin
                // shared prefix longer than the previous key
                m = $urandom_range(0, 1) ? prev + $urandom_range(1, 8) : $urandom_range(128, 65535);
                build_record(m, $urandom_range(0, 3), 0, 0);
                send_record_bytes(rec_bytes.size());
            end
            else if (pick < 88)
            begin
                // shared-count varint with a fifth continuation byte
                n = $urandom_range(0, 2);
                rec_bytes.push_back(8'(6 + n));
                rec_bytes.push_back(8'($urandom));
                repeat (5)
                    rec_bytes.push_back({1'b1, 7'($urandom)});
                repeat (n)
                    rec_bytes.push_back(8'($urandom));
                send_record_bytes(rec_bytes.size());
            end
            else if (pick < 92)
            begin
                // truncated records
                case ($urandom_range(0, 2))
                    0: rec_bytes = '{8'h00};
                    1: rec_bytes = '{8'h01, 8'($urandom)};
                    default: rec_bytes = '{8'h02, 8'($urandom), {1'b1, 7'($urandom)}};
                endcase
                send_record_bytes(rec_bytes.size());
            end
            else if (pick < 96)
            begin
                // reset in the middle of a record
                m = $urandom_range(0, prev);
                build_record(m, $urandom_range(1, 6), 0, 0);
                send_record_bytes($urandom_range(1, rec_bytes.size() - 1));
                send_item(1'b1, 8'($urandom));
            end
            else
            begin
                // junk, then a reset to resync the parser
                repeat ($urandom_range(1, 6))
                    rec_bytes.push_back(8'($urandom));
                send_record_bytes(rec_bytes.size());
                send_item(1'b1, 8'($urandom));
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d resets); checked %0d output bytes, %0d of them errors.",
                 items_sent, reset_items, sb.results_checked, sb.error_results);
        $display("Covered prefix copies, suffix writes, oversize keys, bad prefixes, "
                 , "overlong varints, truncated records and mid-record resets.");
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

[files.f]
sv/pkd_pkg.sv
sv/pkd_ram.sv
sv/pkd_datapath.sv
sv/pkd_ctrl.sv
sv/prefix_key_decompressor_core.sv
sim/testbench.sv
